@@ sv/clhs_pkg.sv @@
// clhs_pkg: constants shared by the column letter histogram core
// no dependencies; imported by column_letter_histogram_sorted_core
`default_nettype none

package clhs_pkg;

  // default sizes for the core parameters
  localparam int COUNT_BITS_DEF    = 32;
  localparam int ALPHABET_SIZE_DEF = 26;

  // character bounds of the counted letters
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = 8'h7a;

  // stream field widths
  localparam int DATA_BYTE_W = 8;
  localparam int LETTER_W    = 5;
  localparam int OUT_COUNT_W = 32;
  localparam int CFG_W       = 16;
  localparam int M_TDATA_W   = 72;  // letter, count, total packed and padded to bytes

  // action codes on s_tuser
  localparam logic ACT_DATA = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  // configuration register indexes
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_COLUMN = 1'b1;

endpackage

`default_nettype wire

@@ sv/column_letter_histogram_sorted_core.sv @@
// column_letter_histogram_sorted_core: per-column letter histogram with sorted report
// depends on clhs_pkg (constants, field widths, codes)
//
// Usage:
//   s_* carries bytes in (s_tuser = action, s_tdata = data byte). The stream is cut
//   into blocks of 'period' bytes; the byte at 'which_column' of each complete block
//   is counted when it is a lower-case letter. A data byte is taken whenever the core is idle.
//   An end-of-stream transfer starts a report: ALPHABET_SIZE results on m_*, sorted
//   by count, highest first, ties to the earlier letter, m_tlast on the final one.
//   The report is built by a selection sort on one shared compare unit: each result
//   needs one scan over all ALPHABET_SIZE counters followed by a load of the output
//   register. s_tready is low for the whole report.
//   A bad configuration (period or column zero, column beyond period) drops data
//   bytes and answers end of stream with one error result (m_tuser high).
//   After a report the counters, total and block position are cleared.
//   A stalled receiver holds the output register; the sequencer waits for it.
//   cfg_* writes period (index 0) or which_column (index 1); always ready.
//   Reset: period and column return to 1, all counters and the output clear.
`default_nettype none

module column_letter_histogram_sorted_core #(
  parameter int COUNT_BITS    = clhs_pkg::COUNT_BITS_DEF,
  parameter int ALPHABET_SIZE = clhs_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [clhs_pkg::DATA_BYTE_W-1:0]  s_tdata,   // [7:0] data_byte
  input  wire logic                              s_tuser,   // [0] action
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [clhs_pkg::M_TDATA_W-1:0]         m_tdata,   // [4:0] letter, [36:5] letter_count,
                                                            // [68:37] total, [71:69] zero
  output logic                                   m_tuser,   // [0] error
  output logic                                   m_tlast,   // last
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_index,
  input  wire logic [clhs_pkg::CFG_W-1:0]        cfg_data
);

  import clhs_pkg::*;

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [7:0] ALPHA_N = 8'(ALPHABET_SIZE);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUT  = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0]            state;
  logic [CFG_W-1:0]      period;
  logic [CFG_W-1:0]      which_column;
  logic [COUNT_BITS-1:0] cnt [ALPHABET_SIZE];
  logic [COUNT_BITS-1:0] total;
  logic [CFG_W-1:0]      block_pos;
  logic [IDX_W-1:0]      pend_letter;
  logic                  pend_valid;

  // sort bookkeeping
  logic [ALPHABET_SIZE-1:0] emitted;
  logic [IDX_W-1:0]         scan_idx;
  logic [IDX_W-1:0]         rank;
  logic [IDX_W-1:0]         best_idx;
  logic [COUNT_BITS-1:0]    best_cnt;
  logic                     best_valid;

  logic cfg_ok;
  logic in_xfer;
  logic byte_step;
  logic hit;
  logic is_letter;
  logic [7:0]       letter_off;
  logic [CFG_W:0]   pos_inc;
  logic             block_done;
  logic [IDX_W-1:0] pl_next;
  logic             pv_next;
  logic             count_en;
  logic             out_free;
  logic             clear_store;
  logic             take_better;
  logic [COUNT_BITS-1:0] scan_cnt;
  logic [63:0]      best_cnt_ext;
  logic [63:0]      total_ext;
  logic [7:0]       best_idx_ext;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign cfg_ok = (period != '0) && (which_column != '0) && (which_column <= period);

  // data byte path: latch the chosen column, count on block completion
  assign byte_step  = in_xfer && (s_tuser == ACT_DATA) && cfg_ok;
  assign pos_inc    = {1'b0, block_pos} + 1'b1;
  assign hit        = (pos_inc == {1'b0, which_column});
  assign letter_off = s_tdata - CHAR_A;
  assign is_letter  = (s_tdata >= CHAR_A) && (s_tdata <= CHAR_Z) && (letter_off < ALPHA_N);
  assign pl_next    = hit ? (is_letter ? letter_off[IDX_W-1:0] : '0) : pend_letter;
  assign pv_next    = hit ? is_letter : pend_valid;
  assign block_done = (pos_inc >= {1'b0, period});
  assign count_en   = byte_step && block_done && pv_next;

  // end of report or error result clears the store
  assign clear_store = out_free &&
                       ((state == ST_ERR) || ((state == ST_PUT) && (rank == IDX_LAST)));

  // shared compare unit of the selection sort
  assign scan_cnt    = cnt[scan_idx];
  assign take_better = !emitted[scan_idx] && (!best_valid || (scan_cnt > best_cnt));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period       <= CFG_W'(1);
      which_column <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PERIOD) begin
        period <= cfg_data;
      end else begin
        which_column <= cfg_data;
      end
    end
  end

  // letter counters, each with its own saturating increment
  always_ff @(posedge clk) begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (rst || clear_store) begin
        cnt[i] <= '0;
      end else if (count_en && (pl_next == IDX_W'(i)) && (cnt[i] != '1)) begin
        cnt[i] <= cnt[i] + 1'b1;
      end
    end
  end

  // total and block position
  always_ff @(posedge clk) begin
    if (rst || clear_store) begin
      total       <= '0;
      block_pos   <= '0;
      pend_letter <= '0;
      pend_valid  <= 1'b0;
    end else if (byte_step) begin
      if (count_en && (total != '1)) begin
        total <= total + 1'b1;
      end
      if (block_done) begin
        block_pos   <= '0;
        pend_letter <= '0;
        pend_valid  <= 1'b0;
      end else begin
        block_pos   <= pos_inc[CFG_W-1:0];
        pend_letter <= pl_next;
        pend_valid  <= pv_next;
      end
    end
  end

  // report sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      emitted    <= '0;
      scan_idx   <= '0;
      rank       <= '0;
      best_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer && (s_tuser == ACT_EOS)) begin
            emitted    <= '0;
            scan_idx   <= '0;
            rank       <= '0;
            best_valid <= 1'b0;
            state      <= cfg_ok ? ST_SCAN : ST_ERR;
          end
        end
        ST_SCAN: begin
          if (take_better) begin
            best_valid <= 1'b1;
          end
          if (scan_idx == IDX_LAST) begin
            state <= ST_PUT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            emitted[best_idx] <= 1'b1;
            scan_idx          <= '0;
            best_valid        <= 1'b0;
            if (rank == IDX_LAST) begin
              state <= ST_IDLE;
            end else begin
              rank  <= rank + 1'b1;
              state <= ST_SCAN;
            end
          end
        end
        ST_ERR: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // best candidate of the current scan
  always_ff @(posedge clk) begin
    if ((state == ST_SCAN) && take_better) begin
      best_idx <= scan_idx;
      best_cnt <= scan_cnt;
    end
  end

  assign best_cnt_ext = 64'(best_cnt);
  assign total_ext    = 64'(total);
  assign best_idx_ext = 8'(best_idx);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= (state == ST_PUT) || (state == ST_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == ST_PUT) begin
        m_tdata <= {3'b000, total_ext[OUT_COUNT_W-1:0], best_cnt_ext[OUT_COUNT_W-1:0],
                    best_idx_ext[LETTER_W-1:0]};
        m_tuser <= 1'b0;
        m_tlast <= (rank == IDX_LAST);
      end else if (state == ST_ERR) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
        m_tlast <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_column_letter_histogram_sorted_core.sv @@
// tb_column_letter_histogram_sorted_core: self-checking bench for the column letter histogram core
// holds a tally model in a small class, directed and random byte streams, random stalls
// depends on clhs_pkg and column_letter_histogram_sorted_core
module tb_column_letter_histogram_sorted_core;
  timeunit 1ns;
  timeprecision 1ps;
  import clhs_pkg::*;

  localparam int          ALPHA         = 26;
  localparam logic [31:0] COUNT_TOP     = 32'hffff_ffff;
  localparam int          CYCLE_LIMIT   = 3000000;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          RANDOM_ITEMS  = 400;
  localparam int          QUIET_FROM    = 320;
  localparam int          LOUD_LIMIT    = 10;

  // one line of a sorted report
  typedef struct packed {
    logic [4:0]  letter;
    logic [31:0] count;
    logic [31:0] total;
    logic        error;
    logic        last;
  } rank_row_t;

  // letter tally of the chosen column, with the report lines still awaited
  class column_tally;
    logic [15:0] period_r;
    logic [15:0] column_r;
    logic [31:0] counts [ALPHA];
    logic [31:0] total_r;
    int unsigned pos_r;
    logic [4:0]  pend_letter;
    bit          pend_valid;
    rank_row_t   ranked_rows [$];
    int unsigned faults;

    function new();
      period_r = 16'd1;
      column_r = 16'd1;
      faults   = 0;
      clear_store();
    endfunction

    function void clear_store();
      for (int i = 0; i < ALPHA; i++) counts[i] = '0;
      total_r     = '0;
      pos_r       = 0;
      pend_letter = '0;
      pend_valid  = 1'b0;
    endfunction

    function bit setting_ok();
      return period_r != 0 && column_r != 0 && column_r <= period_r;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == REG_PERIOD) period_r = val;
      else column_r = val;
    endfunction

    // accepted input transfer: advance the tally, queue any report lines
    function void absorb(logic act, logic [7:0] b);
      int unsigned nxt;
      bit          taken [ALPHA];
      int          best;
      rank_row_t   row;
      if (act == ACT_DATA) begin
        if (!setting_ok()) return;
        nxt = pos_r + 1;
        // latch the byte at the chosen column
        if (nxt == column_r) begin
          if (b >= CHAR_A && b <= CHAR_Z) begin
            pend_letter = 5'(b - CHAR_A);
            pend_valid  = 1'b1;
          end else begin
            pend_letter = '0;
            pend_valid  = 1'b0;
          end
        end
        // block complete: count the held letter, saturating
        if (nxt >= period_r) begin
          if (pend_valid) begin
            if (counts[pend_letter] != COUNT_TOP) counts[pend_letter]++;
            if (total_r != COUNT_TOP) total_r++;
          end
          pos_r       = 0;
          pend_letter = '0;
          pend_valid  = 1'b0;
        end else begin
          pos_r = nxt;
        end
        return;
      end
      // end of stream under a bad setting: single error line
      if (!setting_ok()) begin
        row       = '0;
        row.error = 1'b1;
        row.last  = 1'b1;
        ranked_rows.insert(ranked_rows.size(), row);
        clear_store();
        return;
      end
      // rank by count, highest first, ties to the earlier letter
      for (int i = 0; i < ALPHA; i++) taken[i] = 1'b0;
      for (int r = 0; r < ALPHA; r++) begin
        best = -1;
        for (int l = 0; l < ALPHA; l++) begin
          if (!taken[l] && (best < 0 || counts[l] > counts[best])) best = l;
        end
        taken[best] = 1'b1;
        row.letter  = 5'(best);
        row.count   = counts[best];
        row.total   = total_r;
        row.error   = 1'b0;
        row.last    = (r == ALPHA - 1);
        ranked_rows.insert(ranked_rows.size(), row);
      end
      clear_store();
    endfunction

    // accepted result transfer against the oldest awaited line
    function void match_rank(rank_row_t got);
      rank_row_t want;
      if (ranked_rows.size() == 0) begin
        faults++;
        if (faults <= LOUD_LIMIT)
          $display("unexpected result: letter %0d count %0d total %0d error %0b last %0b",
                   got.letter, got.count, got.total, got.error, got.last);
        return;
      end
      want = ranked_rows.pop_front();
      if (got.letter !== want.letter || got.count !== want.count ||
          got.total !== want.total || got.error !== want.error || got.last !== want.last) begin
        faults++;
        if (faults <= LOUD_LIMIT) begin
          $display("mismatch: expected letter %0d count %0d total %0d error %0b last %0b",
                   want.letter, want.count, want.total, want.error, want.last);
          $display("          actual   letter %0d count %0d total %0d error %0b last %0b",
                   got.letter, got.count, got.total, got.error, got.last);
        end
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [DATA_BYTE_W-1:0] s_tdata   = '0;
  logic                   s_tuser   = ACT_DATA;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = REG_PERIOD;
  logic [CFG_W-1:0]       cfg_data  = '0;

  column_tally tally;
  rank_row_t   seen_row;
  bit          quiet      = 1'b0;
  int          rand_count = 0;
  int          cycle_count = 0;

  column_letter_histogram_sorted_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("column_letter_histogram_sorted_core regression: fail");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_row.letter = m_tdata[4:0];
      seen_row.count  = m_tdata[36:5];
      seen_row.total  = m_tdata[68:37];
      seen_row.error  = m_tuser;
      seen_row.last   = m_tlast;
      tally.match_rank(seen_row);
    end
  end

  // receiver stalls in bursts
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (quiet) begin
        m_tready = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        burst    = $urandom_range(1, 11);
        m_tready = 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        burst    = $urandom_range(1, 16);
        m_tready = 1'b1;
        repeat (burst - 1) @(negedge clk);
      end
    end
  end

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_item(logic act, logic [7:0] b);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 11);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = act;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    tally.absorb(act, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_DATA, s[i]);
  endtask

  // stop sending until every awaited line is in, then let the core go quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (tally.ranked_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    tally.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one random run: a setting, a byte stream, mostly closed by end of stream
  task automatic random_phase();
    int          kind;
    int          n;
    logic [15:0] p;
    logic [15:0] c;
    logic [7:0]  b;
    logic        act;
    kind = $urandom_range(0, 19);
    p    = tally.period_r;
    c    = tally.column_r;
    if (kind < 12) begin
      p = 16'($urandom_range(1, 8));
      c = 16'($urandom_range(1, p));
    end else if (kind < 14) begin
      p = 16'($urandom_range(9, 300));
      c = 16'($urandom_range(1, p));
    end else if (kind == 14) begin
      p = 16'($urandom_range(1, 16'hffff));
      c = 16'($urandom_range(1, p));
    end else if (kind == 15) begin
      p = '0;
      c = 16'($urandom);
    end else if (kind == 16) begin
      p = 16'($urandom_range(1, 16'hffff));
      c = '0;
    end else if (kind == 17) begin
      p = 16'($urandom_range(1, 16'hfffe));
      c = 16'($urandom_range(p + 1, 16'hffff));
    end else if (kind == 18) begin
      p = 16'($urandom_range(1, 4));
    end
    // kind 19 keeps the current setting and carries on mid-block
    if (kind != 19) begin
      settle();
      if (kind == 18) begin
        write_cfg(REG_PERIOD, p);
      end else if ($urandom_range(0, 1) == 1) begin
        write_cfg(REG_COLUMN, c);
        write_cfg(REG_PERIOD, p);
      end else begin
        write_cfg(REG_PERIOD, p);
        write_cfg(REG_COLUMN, c);
      end
    end
    n = $urandom_range(4, 40);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) b = CHAR_A + 8'($urandom_range(0, ALPHA - 1));
      else b = 8'($urandom);
      act = ($urandom_range(0, 49) == 0) ? ACT_EOS : ACT_DATA;
      if (act == ACT_EOS || tally.setting_ok()) rand_count++;
      send_item(act, b);
    end
    if ($urandom_range(0, 4) != 0) begin
      rand_count++;
      send_item(ACT_EOS, 8'($urandom));
      if ($urandom_range(0, 2) == 0) settle();
    end
  endtask

  // stimulus
  initial begin
    tally = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset setting: every byte is its own block; letter bounds and non-letters
    send_item(ACT_DATA, "a");
    send_item(ACT_DATA, "z");
    send_item(ACT_DATA, 8'h60);
    send_item(ACT_DATA, 8'h7b);
    send_item(ACT_DATA, 8'h00);
    send_item(ACT_DATA, 8'hff);
    send_item(ACT_DATA, "a");
    send_item(ACT_EOS, 8'h00);
    // empty report: all ties, letters in order
    send_item(ACT_EOS, 8'hff);

    // blocks of three, middle column; partial block at the end is dropped
    settle();
    write_cfg(REG_PERIOD, 16'd3);
    write_cfg(REG_COLUMN, 16'd2);
    send_text("xbyqc");
    send_item(ACT_EOS, 8'h5a);

    // period shrunk below the position mid-block
    settle();
    write_cfg(REG_PERIOD, 16'd5);
    write_cfg(REG_COLUMN, 16'd1);
    send_text("mno");
    settle();
    write_cfg(REG_PERIOD, 16'd2);
    send_text("kzz");
    send_item(ACT_EOS, 8'h00);

    // bad settings: zero period, zero column, column past period
    settle();
    write_cfg(REG_PERIOD, 16'd0);
    send_item(ACT_DATA, "a");
    send_item(ACT_EOS, 8'h00);
    settle();
    write_cfg(REG_PERIOD, 16'd4);
    write_cfg(REG_COLUMN, 16'd0);
    send_item(ACT_EOS, 8'h00);
    settle();
    write_cfg(REG_COLUMN, 16'd5);
    send_item(ACT_EOS, 8'h00);

    // widest setting
    settle();
    write_cfg(REG_PERIOD, 16'hffff);
    write_cfg(REG_COLUMN, 16'hffff);
    send_text("ab");
    send_item(ACT_EOS, 8'h00);

    // random runs, quiet towards the end
    while (rand_count < RANDOM_ITEMS) begin
      if (rand_count >= QUIET_FROM) quiet = 1'b1;
      random_phase();
    end

    settle();
    repeat (40) @(posedge clk);
    if (tally.faults == 0 && tally.ranked_rows.size() == 0) begin
      $display("column_letter_histogram_sorted_core regression: pass");
    end else begin
      $display("column_letter_histogram_sorted_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/clhs_pkg.sv
sv/column_letter_histogram_sorted_core.sv
verif/tb_column_letter_histogram_sorted_core.sv
